// File: rtl/ofmt_pkg.sv
// ----------------------------------------------------------------------------
// ofmt_pkg: octal field formatter package
// Character constants, microcode word layout, step codes and program table.
// ----------------------------------------------------------------------------
package ofmt_pkg;

	localparam int FIELD_MAX = 63;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int DIG_GROUPS = 22;
	localparam int DIG_BITS   = 3 * DIG_GROUPS;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_SCAN = 3'd1;
	localparam step_t STEP_CALC = 3'd2;
	localparam step_t STEP_PADL = 3'd3;
	localparam step_t STEP_LEAD = 3'd4;
	localparam step_t STEP_DIGS = 3'd5;
	localparam step_t STEP_PADR = 3'd6;

	typedef enum logic [1:0] {
		OP_WAIT = 2'd0,
		OP_SCAN = 2'd1,
		OP_CALC = 2'd2,
		OP_EMIT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CNT_PAD  = 2'd0,
		CNT_LEAD = 2'd1,
		CNT_DIG  = 2'd2
	} cnt_t;

	typedef enum logic [1:0] {
		SRC_PAD   = 2'd0,
		SRC_ZERO  = 2'd1,
		SRC_DIGIT = 2'd2,
		SRC_SPACE = 2'd3
	} src_t;

	typedef enum logic [1:0] {
		COND_NONE     = 2'd0,
		COND_MINUS    = 2'd1,
		COND_NO_MINUS = 2'd2
	} cond_t;

	typedef struct packed {
		op_t   op;
		cnt_t  cnt;
		src_t  src;
		cond_t skip;
		step_t next;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			STEP_IDLE: w = '{OP_WAIT, CNT_PAD,  SRC_PAD,   COND_NONE,     STEP_SCAN};
			STEP_SCAN: w = '{OP_SCAN, CNT_DIG,  SRC_DIGIT, COND_NONE,     STEP_CALC};
			STEP_CALC: w = '{OP_CALC, CNT_PAD,  SRC_PAD,   COND_NONE,     STEP_PADL};
			STEP_PADL: w = '{OP_EMIT, CNT_PAD,  SRC_PAD,   COND_MINUS,    STEP_LEAD};
			STEP_LEAD: w = '{OP_EMIT, CNT_LEAD, SRC_ZERO,  COND_NONE,     STEP_DIGS};
			STEP_DIGS: w = '{OP_EMIT, CNT_DIG,  SRC_DIGIT, COND_NONE,     STEP_PADR};
			STEP_PADR: w = '{OP_EMIT, CNT_PAD,  SRC_SPACE, COND_NO_MINUS, STEP_IDLE};
			default:   w = '{OP_WAIT, CNT_PAD,  SRC_PAD,   COND_NONE,     STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/ofmt_if.sv
// ----------------------------------------------------------------------------
// ofmt_if: octal field formatter channels
// Request channel carrying one value to format, and the character channel.
// ----------------------------------------------------------------------------
interface ofmt_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  size_code;
	logic [5:0]  field_width;
	logic [5:0]  min_digits;
	logic        precision_given;
	logic        flag_zero;
	logic        flag_minus;
	logic        flag_hash;

	modport source (
		output valid, value, size_code, field_width, min_digits,
		       precision_given, flag_zero, flag_minus, flag_hash,
		input  ready
	);
	modport sink (
		input  valid, value, size_code, field_width, min_digits,
		       precision_given, flag_zero, flag_minus, flag_hash,
		output ready
	);
endinterface

interface ofmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

// File: rtl/octal_field_formatter_core.sv
// ----------------------------------------------------------------------------
// octal_field_formatter_core: printf %o formatter
// The leading-zero scan runs one digit a cycle, then one character leaves per
// cycle from the microcode emit steps unless the character channel stalls
// with a character still held in the output register.
// One request at a time; the next is taken when the sequencer is back idle.
// Reset clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module octal_field_formatter_core import ofmt_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	ofmt_in_if.sink     item,
	ofmt_out_if.source  text
);

	step_t                 step_q;
	logic [DIG_BITS-1:0]   digits_q;
	logic [4:0]            nd_q;
	logic [5:0]            width_q;
	logic [5:0]            prec_q;
	logic                  given_q;
	logic                  zero_q;
	logic                  minus_q;
	logic                  hash_q;
	logic [5:0]            pad_q;
	logic [5:0]            lead_q;
	logic [5:0]            total_q;
	logic                  zpad_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	ucode_t                cw;
	logic                  accept;
	logic [63:0]           masked;
	logic [5:0]            width_c;
	logic [5:0]            prec_c;
	logic [5:0]            nd6;
	logic [5:0]            body;
	logic [5:0]            cnt;
	logic                  skip;
	logic                  emit_ok;
	logic                  emit;
	logic                  scan_shift;
	logic                  advance;
	logic [7:0]            char_c;

	function automatic logic [5:0] clamp_field(input logic [5:0] x);
		logic [5:0] r;
		r = x;
		if (int'(x) > FIELD_MAX)
			r = FIELD_MAX[5:0];
		return r;
	endfunction

	always_comb begin
		cw      = ucode_rom(step_q);
		accept  = item.valid && item.ready;
		emit_ok = !out_valid_q || text.ready;

		case (item.size_code)
			2'd0:    masked = {56'd0, item.value[7:0]};
			2'd1:    masked = {48'd0, item.value[15:0]};
			2'd2:    masked = {32'd0, item.value[31:0]};
			default: masked = item.value;
		endcase
		width_c = clamp_field(item.field_width);
		prec_c  = item.precision_given ? clamp_field(item.min_digits) : 6'd1;

		nd6  = {1'b0, nd_q};
		body = (nd6 > prec_q) ? nd6 : prec_q;
		if (hash_q && body == nd6)
			body = nd6 + 6'd1;

		case (cw.cnt)
			CNT_PAD:  cnt = pad_q;
			CNT_LEAD: cnt = lead_q;
			CNT_DIG:  cnt = nd6;
			default:  cnt = 6'd0;
		endcase

		case (cw.skip)
			COND_MINUS:    skip = minus_q;
			COND_NO_MINUS: skip = !minus_q;
			default:       skip = 1'b0;
		endcase

		case (cw.src)
			SRC_PAD:   char_c = zpad_q ? CH_ZERO : CH_SPACE;
			SRC_ZERO:  char_c = CH_ZERO;
			SRC_DIGIT: char_c = CH_ZERO + {5'd0, digits_q[DIG_BITS-1 -: 3]};
			default:   char_c = CH_SPACE;
		endcase

		scan_shift = (cw.op == OP_SCAN) && nd_q != 5'd0 &&
		             digits_q[DIG_BITS-1 -: 3] == 3'd0;
		emit       = (cw.op == OP_EMIT) && !skip && cnt != 6'd0 && emit_ok;

		case (cw.op)
			OP_WAIT: advance = accept;
			OP_SCAN: advance = !scan_shift;
			OP_CALC: advance = 1'b1;
			OP_EMIT: advance = skip || cnt == 6'd0 || (emit && cnt == 6'd1);
			default: advance = 1'b1;
		endcase
	end

	assign item.ready     = (cw.op == OP_WAIT);
	assign text.valid     = out_valid_q;
	assign text.out_char  = out_char_q;
	assign text.last_char = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				step_q <= cw.next;
			if (emit)
				out_valid_q <= 1'b1;
			else if (text.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			digits_q <= {{(DIG_BITS-64){1'b0}}, masked};
			nd_q     <= 5'(DIG_GROUPS);
			width_q  <= width_c;
			prec_q   <= prec_c;
			given_q  <= item.precision_given;
			zero_q   <= item.flag_zero;
			minus_q  <= item.flag_minus;
			hash_q   <= item.flag_hash;
		end
		if (scan_shift) begin
			digits_q <= {digits_q[DIG_BITS-4:0], 3'd0};
			nd_q     <= nd_q - 5'd1;
		end
		if (cw.op == OP_CALC) begin
			pad_q   <= (width_q > body) ? width_q - body : 6'd0;
			lead_q  <= body - nd6;
			total_q <= (width_q > body) ? width_q : body;
			zpad_q  <= zero_q && !given_q && !minus_q;
		end
		if (emit) begin
			out_char_q <= char_c;
			out_last_q <= (total_q == 6'd1);
			total_q    <= total_q - 6'd1;
			case (cw.cnt)
				CNT_PAD:  pad_q  <= pad_q - 6'd1;
				CNT_LEAD: lead_q <= lead_q - 6'd1;
				CNT_DIG: begin
					nd_q     <= nd_q - 5'd1;
					digits_q <= {digits_q[DIG_BITS-4:0], 3'd0};
				end
				default: ;
			endcase
		end
	end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: octal field formatter testbench
// Sends format requests with bursty timing, stalls the character channel on
// shifting patterns, predicts every character of each %o run and checks the
// text stream in order, including the last-of-run mark.
// ----------------------------------------------------------------------------

typedef struct {
	logic [63:0] value;
	logic [1:0]  size_code;
	logic [5:0]  field_width;
	logic [5:0]  min_digits;
	logic        precision_given;
	logic        flag_zero;
	logic        flag_minus;
	logic        flag_hash;
} fmt_request_t;

typedef struct {
	logic [7:0] ch;
	logic       last;
} glyph_t;

class octal_text_board;
	glyph_t expected_glyphs[$];
	int     errors;

	function new();
		errors = 0;
	endfunction

	function int pending();
		return expected_glyphs.size();
	endfunction

	function void note_request(fmt_request_t r);
		logic [63:0] v;
		logic [7:0]  digs[24];
		logic [7:0]  run[64];
		int          nd, body, width, prec, pad, n, i;
		bit          zero_pad;
		glyph_t      g;
		case (r.size_code)
			2'd0: v = r.value & 64'h0000_0000_0000_00FF;
			2'd1: v = r.value & 64'h0000_0000_0000_FFFF;
			2'd2: v = r.value & 64'h0000_0000_FFFF_FFFF;
			default: v = r.value;
		endcase
		nd = 0;
		while (v != 0 && nd < 24) begin
			digs[nd] = ofmt_pkg::CH_ZERO + {5'd0, v[2:0]};
			nd++;
			v = v >> 3;
		end
		width = int'(r.field_width);
		if (width > ofmt_pkg::FIELD_MAX)
			width = ofmt_pkg::FIELD_MAX;
		prec = 1;
		if (r.precision_given) begin
			prec = int'(r.min_digits);
			if (prec > ofmt_pkg::FIELD_MAX)
				prec = ofmt_pkg::FIELD_MAX;
		end
		body = (nd > prec) ? nd : prec;
		if (r.flag_hash && body == nd)
			body = nd + 1;
		if (body > 63)
			body = 63;
		pad = (width > body) ? width - body : 0;
		zero_pad = r.flag_zero && !r.precision_given && !r.flag_minus;
		n = 0;
		if (!r.flag_minus)
			for (i = 0; i < pad && n < 63; i++) begin
				run[n] = zero_pad ? ofmt_pkg::CH_ZERO : ofmt_pkg::CH_SPACE;
				n++;
			end
		for (i = nd; i < body && n < 63; i++) begin
			run[n] = ofmt_pkg::CH_ZERO;
			n++;
		end
		for (i = nd; i > 0 && n < 63; i--) begin
			run[n] = digs[i - 1];
			n++;
		end
		if (r.flag_minus)
			for (i = 0; i < pad && n < 63; i++) begin
				run[n] = ofmt_pkg::CH_SPACE;
				n++;
			end
		for (i = 0; i < n; i++) begin
			g.ch = run[i];
			g.last = (i == n - 1);
			expected_glyphs.push_back(g);
		end
	endfunction

	function void check_glyph(logic [7:0] ch, logic last);
		glyph_t g;
		if (expected_glyphs.size() == 0) begin
			$display("%0t: unexpected character: expected none, actual %h last %b",
				$time, ch, last);
			errors++;
			return;
		end
		g = expected_glyphs.pop_front();
		if (ch !== g.ch) begin
			$display("%0t: out_char mismatch: expected %h, actual %h", $time, g.ch, ch);
			errors++;
		end
		if (last !== g.last) begin
			$display("%0t: last_char mismatch: expected %b, actual %b",
				$time, g.last, last);
			errors++;
		end
	endfunction
endclass

module tb;
	import ofmt_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int IDLE_LIMIT   = 3000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 150;

	logic clk;
	logic arst_n;

	ofmt_in_if  req_ch();
	ofmt_out_if text_ch();

	octal_field_formatter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.text   (text_ch)
	);

	octal_text_board board;
	int idle_cycles;
	bit long_hold_go;
	bit long_hold_done;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic fmt_request_t make_req(logic [63:0] value, logic [1:0] size_code,
			int fw, int md, bit given, bit zero, bit minus, bit hash);
		fmt_request_t r;
		r.value = value;
		r.size_code = size_code;
		r.field_width = fw[5:0];
		r.min_digits = md[5:0];
		r.precision_given = given;
		r.flag_zero = zero;
		r.flag_minus = minus;
		r.flag_hash = hash;
		return r;
	endfunction

	function automatic fmt_request_t random_req();
		fmt_request_t r;
		logic [63:0]  v;
		int           pick;
		v = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 4)
			v = v >> $urandom_range(0, 63);
		else if (pick == 4)
			v = 64'd0;
		else if (pick == 5)
			v = 64'($urandom_range(0, 7));
		r.value = v;
		r.size_code = 2'($urandom_range(0, 3));
		r.field_width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 15));
		r.min_digits = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 12));
		r.precision_given = 1'($urandom_range(0, 1));
		r.flag_zero = 1'($urandom_range(0, 1));
		r.flag_minus = 1'($urandom_range(0, 1));
		r.flag_hash = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_request(fmt_request_t r);
		req_ch.valid <= 1'b1;
		req_ch.value <= r.value;
		req_ch.size_code <= r.size_code;
		req_ch.field_width <= r.field_width;
		req_ch.min_digits <= r.min_digits;
		req_ch.precision_given <= r.precision_given;
		req_ch.flag_zero <= r.flag_zero;
		req_ch.flag_minus <= r.flag_minus;
		req_ch.flag_hash <= r.flag_hash;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic idle_sender(int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic wait_text_drained();
		@(posedge clk);
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			board.note_request('{req_ch.value, req_ch.size_code, req_ch.field_width,
				req_ch.min_digits, req_ch.precision_given, req_ch.flag_zero,
				req_ch.flag_minus, req_ch.flag_hash});
		if (text_ch.valid && text_ch.ready)
			board.check_glyph(text_ch.out_char, text_ch.last_char);
		if ((req_ch.valid && req_ch.ready) || (text_ch.valid && text_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int seg;
		int mode;
		text_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (long_hold_go && !long_hold_done) begin
				repeat (LONG_HOLD) begin
					@(posedge clk);
					text_ch.ready <= 1'b0;
				end
				long_hold_done = 1'b1;
			end
			seg = $urandom_range(1, 40);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				@(posedge clk);
				case (mode)
					0: text_ch.ready <= 1'b1;
					1: text_ch.ready <= 1'($urandom_range(0, 1));
					2: text_ch.ready <= ($urandom_range(0, 3) == 0);
					default: text_ch.ready <= ~text_ch.ready;
				endcase
			end
		end
	end

	initial begin
		fmt_request_t directed[$];
		int burst_left;
		int k;
		board = new();
		idle_cycles = 0;
		long_hold_go = 1'b0;
		long_hold_done = 1'b0;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.value <= '0;
		req_ch.size_code <= '0;
		req_ch.field_width <= '0;
		req_ch.min_digits <= '0;
		req_ch.precision_given <= 1'b0;
		req_ch.flag_zero <= 1'b0;
		req_ch.flag_minus <= 1'b0;
		req_ch.flag_hash <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_req(64'd0, 2'd3, 0, 0, 1, 0, 0, 0));
		directed.push_back(make_req(64'd0, 2'd3, 0, 0, 1, 0, 0, 1));
		directed.push_back(make_req(64'd0, 2'd2, 5, 0, 1, 0, 0, 0));
		directed.push_back(make_req(64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req('1, 2'd3, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req('1, 2'd0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req('1, 2'd1, 0, 0, 0, 0, 0, 1));
		directed.push_back(make_req('1, 2'd2, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req('1, 2'd3, 63, 63, 1, 1, 1, 1));
		directed.push_back(make_req(64'd8, 2'd3, 0, 5, 1, 0, 0, 1));
		directed.push_back(make_req(64'd8, 2'd3, 0, 0, 0, 0, 0, 1));
		directed.push_back(make_req(64'o1234, 2'd1, 10, 0, 0, 1, 0, 0));
		directed.push_back(make_req(64'o1234, 2'd1, 10, 6, 1, 1, 0, 0));
		directed.push_back(make_req(64'o1234, 2'd1, 10, 0, 0, 1, 1, 0));
		directed.push_back(make_req(64'd1, 2'd0, 63, 0, 0, 0, 1, 0));
		directed.push_back(make_req('1, 2'd3, 63, 0, 0, 1, 0, 1));
		directed.push_back(make_req(64'd7, 2'd0, 1, 0, 0, 0, 0, 0));
		directed.push_back(make_req(64'h8000_0000_0000_0000, 2'd3, 0, 63, 1, 0, 0, 1));
		directed.push_back(make_req(64'hFFFF_FFFF_FFFF_FF00, 2'd0, 3, 1, 1, 0, 0, 1));
		directed.push_back(make_req(64'd0, 2'd1, 63, 0, 0, 1, 0, 0));
		foreach (directed[i])
			send_request(directed[i]);
		idle_sender(3);
		wait_text_drained();

		burst_left = $urandom_range(1, 12);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 150)
				long_hold_go = 1'b1;
			send_request(random_req());
			if (k == 300) begin
				idle_sender(1);
				wait_text_drained();
			end
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				if (!(long_hold_go && !long_hold_done) && $urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 25));
			end
		end
		idle_sender(1);
		wait_text_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
